// File: rtl/core/bta_pkg.sv
package bta_pkg;

  // Fixed field widths of the task-file translation
  localparam int unsigned BlockWordW      = 32;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned HeadsW          = 5;
  localparam int unsigned CfgIndexW       = 3;
  localparam int unsigned CfgDataW        = 8;
  localparam int unsigned BlockNumBitsDef = 32;

  // Register reset values
  localparam logic               LbaModeRst   = 1'b1;
  localparam logic [HeadsW-1:0]  HeadsRst     = 5'd16;
  localparam logic [ByteW-1:0]   SptRst       = 8'd63;
  localparam logic [ByteW-1:0]   DriveSelRst  = 8'd160;
  localparam logic [ByteW-1:0]   LbaFlagRst   = 8'd64;

  typedef enum logic [CfgIndexW-1:0] {
    REG_LBA_MODE  = 3'd0,
    REG_HEADS     = 3'd1,
    REG_SPT       = 3'd2,
    REG_DRIVE_SEL = 3'd3,
    REG_LBA_FLAG  = 3'd4
  } reg_idx_e;

endpackage

// File: rtl/core/bta_in_if.sv
interface bta_in_if;
  logic                              valid;
  logic                              ready;
  logic [bta_pkg::BlockWordW-1:0]    block_number;
  logic [bta_pkg::ByteW-1:0]         transfer_sectors;

  modport source (output valid, block_number, transfer_sectors, input ready);
  modport sink   (input valid, block_number, transfer_sectors, output ready);
endinterface

// File: rtl/core/bta_out_if.sv
interface bta_out_if;
  logic                       valid;
  logic                       ready;
  logic [bta_pkg::ByteW-1:0]  count_byte;
  logic [bta_pkg::ByteW-1:0]  sector_byte;
  logic [bta_pkg::ByteW-1:0]  cylinder_low_byte;
  logic [bta_pkg::ByteW-1:0]  cylinder_high_byte;
  logic [bta_pkg::ByteW-1:0]  drive_head_byte;

  modport source (output valid, count_byte, sector_byte, cylinder_low_byte,
                  cylinder_high_byte, drive_head_byte, input ready);
  modport sink   (input valid, count_byte, sector_byte, cylinder_low_byte,
                  cylinder_high_byte, drive_head_byte, output ready);
endinterface

// File: rtl/core/bta_cfg_if.sv
interface bta_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bta_pkg::CfgIndexW-1:0]  index;
  logic [bta_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/bta_div_cell.sv
// One restoring-division step: bring down one dividend bit, retire one quotient bit.
module bta_div_cell #(
  parameter int unsigned W  = 32,
  parameter int unsigned DW = 8,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [DW-1:0] rem_i,
  input  logic [W-1:0]  acc_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [W-1:0]  acc_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic          valid_q;
  logic [DW-1:0] rem_d, rem_q;
  logic [W-1:0]  acc_d, acc_q;
  logic [SW-1:0] side_q;

  always_comb begin
    trial = {rem_i, acc_i[W-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = (trial >= {1'b0, divisor_i});
    // remainder stays below the divisor, so DW bits hold it
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    acc_d = {acc_i[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      acc_q  <= acc_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule

// File: rtl/core/bta_div_chain.sv
// Row of W division cells; quotient comes out in acc, remainder in rem.
module bta_div_chain #(
  parameter int unsigned W  = 32,
  parameter int unsigned DW = 8,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W-1:0]  quotient_o,
  output logic [DW-1:0] remainder_o,
  output logic [SW-1:0] side_o
);

  logic [W:0]         valid_s;
  logic [W:0][DW-1:0] rem_s;
  logic [W:0][W-1:0]  acc_s;
  logic [W:0][SW-1:0] side_s;

  assign valid_s[0] = valid_i;
  assign rem_s[0]   = '0;
  assign acc_s[0]   = dividend_i;
  assign side_s[0]  = side_i;

  for (genvar i = 0; i < W; i++) begin : g_cell
    bta_div_cell #(
      .W (W),
      .DW(DW),
      .SW(SW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en_i),
      .valid_i  (valid_s[i]),
      .divisor_i(divisor_i),
      .rem_i    (rem_s[i]),
      .acc_i    (acc_s[i]),
      .side_i   (side_s[i]),
      .valid_o  (valid_s[i+1]),
      .rem_o    (rem_s[i+1]),
      .acc_o    (acc_s[i+1]),
      .side_o   (side_s[i+1])
    );
  end

  assign valid_o     = valid_s[W];
  assign quotient_o  = acc_s[W];
  assign remainder_o = rem_s[W];
  assign side_o      = side_s[W];

endmodule

// File: rtl/core/block_to_taskfile_address.sv
// Block number to ATA task-file translation. Each input beat carries a block
// number and a sector count; each output beat carries the five task-file bytes
// (count, sector, cylinder low/high, drive/head). LBA mode slices the block
// number into LBA28 fields; CHS mode divides it by sectors per track, then by
// heads, with a one-based sector and a 16-bit cylinder. Zero geometry is used
// as one. The datapath is two rows of restoring-division cells, one quotient
// bit per cell: the first row divides by sectors per track, the second by
// heads. Every beat passes through both rows in both modes, and one beat
// enters per cycle while the output is taken. The last cell of the second
// row is the output register; a stalled output holds both rows. Program the
// registers only while no beat is in flight.
module block_to_taskfile_address #(
  parameter int unsigned BLOCK_NUMBER_BITS = bta_pkg::BlockNumBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bta_in_if.sink     in_i,
  bta_out_if.source  out_o,
  bta_cfg_if.sink    cfg_i
);

  // Only the bits the port carries can matter
  localparam int unsigned BlkW  = (BLOCK_NUMBER_BITS < bta_pkg::BlockWordW) ?
                                  BLOCK_NUMBER_BITS : bta_pkg::BlockWordW;
  localparam int unsigned ByteW = bta_pkg::ByteW;
  localparam int unsigned HW    = bta_pkg::HeadsW;
  localparam int unsigned Sw1   = ByteW + BlkW;
  localparam int unsigned Sw2   = ByteW + BlkW + ByteW;

  // Configuration registers
  logic              lba_mode_q;
  logic [HW-1:0]     heads_q;
  logic [ByteW-1:0]  spt_q;
  logic [ByteW-1:0]  drive_sel_q;
  logic [ByteW-1:0]  lba_flag_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lba_mode_q  <= bta_pkg::LbaModeRst;
      heads_q     <= bta_pkg::HeadsRst;
      spt_q       <= bta_pkg::SptRst;
      drive_sel_q <= bta_pkg::DriveSelRst;
      lba_flag_q  <= bta_pkg::LbaFlagRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bta_pkg::REG_LBA_MODE:  lba_mode_q  <= cfg_i.data[0];
        bta_pkg::REG_HEADS:     heads_q     <= cfg_i.data[HW-1:0];
        bta_pkg::REG_SPT:       spt_q       <= cfg_i.data;
        bta_pkg::REG_DRIVE_SEL: drive_sel_q <= cfg_i.data;
        bta_pkg::REG_LBA_FLAG:  lba_flag_q  <= cfg_i.data;
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  // Zero geometry divides by one
  logic [ByteW-1:0] spt_div;
  logic [HW-1:0]    heads_div;

  assign spt_div   = (spt_q == '0) ? ByteW'(1) : spt_q;
  assign heads_div = (heads_q == '0) ? HW'(1) : heads_q;

  // Advance both rows unless a finished beat waits at the output
  logic adv;
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // First row: block / sectors_per_track
  logic             v1;
  logic [BlkW-1:0]  q1;
  logic [ByteW-1:0] r1;
  logic [Sw1-1:0]   side1;

  bta_div_chain #(
    .W (BlkW),
    .DW(ByteW),
    .SW(Sw1)
  ) u_div_spt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (in_i.valid),
    .divisor_i  (spt_div),
    .dividend_i (in_i.block_number[BlkW-1:0]),
    .side_i     ({in_i.transfer_sectors, in_i.block_number[BlkW-1:0]}),
    .valid_o    (v1),
    .quotient_o (q1),
    .remainder_o(r1),
    .side_o     (side1)
  );

  // One-based sector; remainder < 255 so it never wraps
  logic [ByteW-1:0] sec1;
  assign sec1 = r1 + ByteW'(1);

  // Second row: (block / sectors_per_track) / heads
  logic             v2;
  logic [BlkW-1:0]  q2;
  logic [HW-1:0]    r2;
  logic [Sw2-1:0]   side2;

  bta_div_chain #(
    .W (BlkW),
    .DW(HW),
    .SW(Sw2)
  ) u_div_heads (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (v1),
    .divisor_i  (heads_div),
    .dividend_i (q1),
    .side_i     ({side1, sec1}),
    .valid_o    (v2),
    .quotient_o (q2),
    .remainder_o(r2),
    .side_o     (side2)
  );

  // Unpack the carried fields
  logic [ByteW-1:0] count_s;
  logic [BlkW-1:0]  blk_s;
  logic [ByteW-1:0] sec_s;

  assign sec_s   = side2[ByteW-1:0];
  assign blk_s   = side2[ByteW +: BlkW];
  assign count_s = side2[ByteW+BlkW +: ByteW];

  // Output beat
  assign out_o.valid      = v2;
  assign out_o.count_byte = count_s;

  always_comb begin
    if (lba_mode_q) begin
      out_o.sector_byte        = blk_s[7:0];
      out_o.cylinder_low_byte  = blk_s[15:8];
      out_o.cylinder_high_byte = blk_s[23:16];
      out_o.drive_head_byte    = {4'b0000, blk_s[27:24]} | lba_flag_q | drive_sel_q;
    end else begin
      out_o.sector_byte        = sec_s;
      out_o.cylinder_low_byte  = q2[7:0];
      out_o.cylinder_high_byte = q2[15:8];
      out_o.drive_head_byte    = {{(ByteW-HW){1'b0}}, r2} | drive_sel_q;
    end
  end

  // Input stalls only behind a held output beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without a held output beat");

  // CHS sector is one-based
  a_chs_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !lba_mode_q) |-> (out_o.sector_byte != '0))
    else $error("CHS sector number is zero");

  // CHS head stays below the head count
  a_chs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !lba_mode_q) |-> (r2 < heads_div))
    else $error("CHS head out of geometry");

  // LBA drive/head always carries the flag and drive-select bits
  a_lba_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && lba_mode_q) |->
      ((out_o.drive_head_byte & (lba_flag_q | drive_sel_q)) == (lba_flag_q | drive_sel_q)))
    else $error("LBA flag or drive select missing in drive/head");

  // A held output beat keeps the row frozen
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1 && out_o.valid && !out_o.ready) |=> v1)
    else $error("first row lost a beat while output held");

endmodule
